// ----- rtl/core/itp_pkg.sv -----
// itp_pkg: shared constants, types and character helpers for the infix to
// prefix converter. No dependencies; imported by itp_stack and the top level.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int LINE_CHARS_DEF = 32;

  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_NULL   = 8'h00;

  // Command from the sequencer to the operator stack.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } stk_cmd_t;

  // Status of the operator stack seen by the sequencer.
  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] top;
  } stk_stat_t;

  function automatic logic [1:0] prec(input logic [7:0] ch);
    logic [1:0] p;
    p = 2'd0;
    if (ch == CH_CARET) begin
      p = 2'd3;
    end else if (ch == CH_STAR || ch == CH_SLASH) begin
      p = 2'd2;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      p = 2'd1;
    end
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] ch);
    logic r;
    r = (ch >= 8'h61 && ch <= 8'h7A) ||   // a..z
        (ch >= 8'h41 && ch <= 8'h5A) ||   // A..Z
        (ch >= 8'h30 && ch <= 8'h39);     // 0..9
    return r;
  endfunction

endpackage

// ----- rtl/core/infix_to_prefix_converter.sv -----
// infix_to_prefix_converter: stores an infix expression, converts it by a
// reversed shunting-yard scan and streams the prefix form. Uses itp_pkg, itp_stack.
//
//   channel | direction | signals                           | transfer when
//   in      | input     | in_char, in_last                  | in_valid & in_ready
//   out     | output    | out_char, out_last, overflow      | out_valid & out_ready
//
// Load: one character per cycle while in_ready is high.
// Convert: a fetch and a decide step per stored character, a decide step per
//   operator popped, then a flush step per operator left and a last one; each
//   step uses the single read port of the operator stack and character buffer.
// Output: each result character is read from the buffer, loaded and transferred;
//   in_ready stays low from the last input transfer to the last output one.
// Reset (rst, synchronous) clears control state only; no clearing pass.
`timescale 1ns / 1ps

module infix_to_prefix_converter
  import itp_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       overflow
);

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int IW = $clog2(LINE_CHARS);

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_DECIDE,
    S_FLUSH,
    S_ORD,
    S_OSHOW,
    S_OHOLD
  } state_t;

  state_t        state;
  logic [CW-1:0] ccount;
  logic [CW-1:0] rcount;
  logic          dropped;

  logic [7:0]    cbuf [LINE_CHARS];
  logic [7:0]    cb_rdata;
  logic [7:0]    rbuf [LINE_CHARS];
  logic [7:0]    rb_rdata;

  stk_cmd_t      stk_cmd;
  stk_stat_t     stk_stat;

  logic          in_xfer;
  logic          store_en;
  logic          emit_en;
  logic [7:0]    emit_char;
  logic          adv;
  logic          emit_room;
  logic [7:0]    cur;

  assign in_ready  = (state == S_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign store_en  = in_xfer && (ccount < CW'(LINE_CHARS));
  assign emit_room = (rcount < CW'(LINE_CHARS));
  assign cur       = cb_rdata;

  itp_stack #(
    .LINE_CHARS(LINE_CHARS)
  ) u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (stk_cmd),
    .stat(stk_stat)
  );

  // Scan decisions for one step of the reversed shunting-yard walk.
  always_comb begin
    stk_cmd   = '0;
    emit_en   = 1'b0;
    emit_char = cur;
    adv       = 1'b0;
    case (state)
      S_DECIDE: begin
        if (is_operand(cur)) begin
          emit_en = emit_room;
          adv     = 1'b1;
        end else if (cur == CH_RPAREN) begin
          stk_cmd.push = 1'b1;
          stk_cmd.data = cur;
          adv          = 1'b1;
        end else if (cur == CH_LPAREN) begin
          if (!stk_stat.empty && stk_stat.top != CH_RPAREN) begin
            stk_cmd.pop = 1'b1;
            emit_en     = emit_room;
            emit_char   = stk_stat.top;
          end else begin
            // Drop the matching ')', or nothing on an empty stack.
            stk_cmd.pop = !stk_stat.empty;
            adv         = 1'b1;
          end
        end else begin
          if (!stk_stat.empty && (prec(cur) < prec(stk_stat.top))) begin
            stk_cmd.pop = 1'b1;
            emit_en     = emit_room;
            emit_char   = stk_stat.top;
          end else begin
            stk_cmd.push = 1'b1;
            stk_cmd.data = cur;
            adv          = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!stk_stat.empty) begin
          stk_cmd.pop = 1'b1;
          emit_en     = emit_room;
          emit_char   = stk_stat.top;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      cbuf[ccount[IW-1:0]] <= in_char;
    end
    cb_rdata <= cbuf[IW'(ccount - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      rbuf[rcount[IW-1:0]] <= emit_char;
    end
    rb_rdata <= rbuf[IW'(rcount - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      ccount    <= '0;
      rcount    <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_en) begin
        rcount <= rcount + 1'b1;
      end
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (store_en) begin
              ccount <= ccount + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (in_last) begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (adv) begin
            ccount <= ccount - 1'b1;
            state  <= (ccount == CW'(1)) ? S_FLUSH : S_FETCH;
          end
        end
        S_FLUSH: begin
          if (stk_stat.empty) begin
            if (rcount != '0) begin
              state <= S_ORD;
            end else begin
              // Nothing collected: send a single null character.
              out_char  <= CH_NULL;
              out_last  <= 1'b1;
              overflow  <= dropped;
              out_valid <= 1'b1;
              state     <= S_OHOLD;
            end
          end
        end
        S_ORD: begin
          state <= S_OSHOW;
        end
        S_OSHOW: begin
          out_char  <= rb_rdata;
          out_last  <= (rcount == CW'(1));
          overflow  <= dropped;
          out_valid <= 1'b1;
          state     <= S_OHOLD;
        end
        S_OHOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              rcount  <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              rcount <= rcount - 1'b1;
              state  <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_valid_in_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OHOLD))
    else $error("result shown outside the hold state");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid && (rcount == '0))
    else $error("input taken while results remain");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ORD) && $past(state == S_FLUSH) |-> stk_stat.empty)
    else $error("output began with operators left on the stack");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (ccount <= CW'(LINE_CHARS)) && (rcount <= CW'(LINE_CHARS)))
    else $error("buffer count beyond capacity");

endmodule

// ----- rtl/core/itp_stack.sv -----
// itp_stack: operator stack for the converter, one write and one registered
// read port, with the top entry tracked in a register. Uses itp_pkg.
`timescale 1ns / 1ps

module itp_stack
  import itp_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int IW = $clog2(LINE_CHARS);

  logic [7:0]    mem [LINE_CHARS];
  logic [7:0]    rdata;
  logic [7:0]    top_reg;
  logic          refill;
  logic [CW-1:0] depth;
  logic [CW-1:0] depth_next;
  logic [IW-1:0] raddr;
  logic          push_ok;
  logic          pop_ok;
  logic          full;

  assign full    = (depth == CW'(LINE_CHARS));
  assign pop_ok  = cmd.pop && (depth != '0);
  assign push_ok = cmd.push && !cmd.pop && !full;

  always_comb begin
    depth_next = depth;
    if (push_ok) begin
      depth_next = depth + 1'b1;
    end else if (pop_ok) begin
      depth_next = depth - 1'b1;
    end
    // Read the entry that will be on top after this cycle.
    raddr = IW'(depth_next - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[depth[IW-1:0]] <= cmd.data;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      refill <= 1'b0;
    end else begin
      depth <= depth_next;
      if (push_ok) begin
        top_reg <= cmd.data;
        refill  <= 1'b0;
      end else if (pop_ok) begin
        refill <= 1'b1;
      end else if (refill) begin
        top_reg <= rdata;
        refill  <= 1'b0;
      end
    end
  end

  assign stat.empty = (depth == '0);
  assign stat.full  = full;
  assign stat.top   = refill ? rdata : top_reg;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CW'(LINE_CHARS))
    else $error("operator stack depth beyond capacity");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> (depth == $past(depth) - 1'b1))
    else $error("pop did not lower depth by one");

  a_push_step: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> (depth == $past(depth) + 1'b1) && !refill)
    else $error("push did not raise depth or left top stale");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for infix_to_prefix_converter.
// Predicts the prefix output of every expression and checks each output transfer.
// Depends on itp_pkg and the converter RTL only.
`timescale 1ns / 1ps

import itp_pkg::*;

typedef struct packed {
  logic [7:0] ch;
  logic       last;
  logic       ovf;
} prefix_char_t;

class prefix_checker;
  logic [7:0]   line_buf [LINE_CHARS_DEF];
  int unsigned  line_len;
  bit           dropped;
  prefix_char_t prefix_due [$];
  int unsigned  errors;

  function new();
    line_len = 0;
    dropped  = 1'b0;
    errors   = 0;
  endfunction

  function int unsigned rank(input logic [7:0] ch);
    case (ch)
      CH_CARET:           return 3;
      CH_STAR, CH_SLASH:  return 2;
      CH_PLUS, CH_MINUS:  return 1;
      default:            return 0;
    endcase
  endfunction

  function bit is_term(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
           (ch >= "0" && ch <= "9");
  endfunction

  function int pending();
    return prefix_due.size();
  endfunction

  task report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Reversed shunting-yard over the stored line; queue the prefix characters.
  function void convert_line();
    logic [7:0]   ops [LINE_CHARS_DEF];
    int unsigned  depth;
    logic [7:0]   collected [$];
    logic [7:0]   c;
    prefix_char_t e;
    int           i;
    depth = 0;
    for (i = line_len; i > 0; i--) begin
      c = line_buf[i-1];
      if (is_term(c)) begin
        collected.push_back(c);
      end else if (c == CH_RPAREN) begin
        if (depth < LINE_CHARS_DEF) begin
          ops[depth] = c;
          depth++;
        end
      end else if (c == CH_LPAREN) begin
        while (depth > 0 && ops[depth-1] != CH_RPAREN) begin
          depth--;
          collected.push_back(ops[depth]);
        end
        // drop the matching ')', if any
        if (depth > 0) depth--;
      end else begin
        while (depth > 0 && rank(c) < rank(ops[depth-1])) begin
          depth--;
          collected.push_back(ops[depth]);
        end
        if (depth < LINE_CHARS_DEF) begin
          ops[depth] = c;
          depth++;
        end
      end
    end
    while (depth > 0) begin
      depth--;
      collected.push_back(ops[depth]);
    end
    if (collected.size() == 0) begin
      e.ch   = CH_NULL;
      e.last = 1'b1;
      e.ovf  = dropped;
      prefix_due.push_back(e);
    end else begin
      for (i = collected.size(); i > 0; i--) begin
        e.ch   = collected[i-1];
        e.last = (i == 1);
        e.ovf  = dropped;
        prefix_due.push_back(e);
      end
    end
    line_len = 0;
    dropped  = 1'b0;
  endfunction

  function void take_char(input logic [7:0] ch, input logic last);
    if (line_len < LINE_CHARS_DEF) begin
      line_buf[line_len] = ch;
      line_len++;
    end else begin
      dropped = 1'b1;
    end
    if (last) convert_line();
  endfunction

  task check_prefix_char(input logic [7:0] ch, input logic last, input logic ovf);
    prefix_char_t e;
    if (prefix_due.size() == 0) begin
      report_mismatch($sformatf("unexpected output char=%h last=%b ovf=%b", ch, last, ovf));
      return;
    end
    e = prefix_due.pop_front();
    if (ch !== e.ch)
      report_mismatch($sformatf("out_char %h, expected %h", ch, e.ch));
    if (last !== e.last)
      report_mismatch($sformatf("out_last %b, expected %b (char %h)", last, e.last, e.ch));
    if (ovf !== e.ovf)
      report_mismatch($sformatf("overflow %b, expected %b (char %h)", ovf, e.ovf, e.ch));
  endtask
endclass

module testbench;

  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD    = 400;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_char   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_last;
  logic       overflow;

  prefix_checker pred = new();

  logic [7:0] line_q [$];
  int         items_sent    = 0;
  bit         no_idle       = 1'b0;
  int         hold_requests = 0;
  int         holds_done    = 0;
  int         hold_left     = 0;
  int         rx_left       = 0;
  int         rx_gap;

  infix_to_prefix_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last),
    .overflow  (overflow)
  );

  always #10 clk = ~clk;

  initial begin
    #100ms;
    $display("infix_to_prefix_converter regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_term();
    case ($urandom_range(0, 2))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  // Watch both channels at the edge; outputs are checked before new input is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) pred.check_prefix_char(out_char, out_last, overflow);
      if (in_valid && in_ready) pred.take_char(in_char, in_last);
    end
  end

  // Receiver: random ready pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done = holds_done + 1;
      hold_left  = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rx_left > 0) begin
      rx_left = rx_left - 1;
    end else if (out_ready) begin
      rx_gap = pick_gap();
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_left = rx_gap - 1;
      end else begin
        rx_left = $urandom_range(0, 15);
      end
    end else begin
      out_ready <= 1'b1;
      rx_left = $urandom_range(0, 15);
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  // Hold the sender until every predicted output has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int depth;
    int terms;
    int len;
    int kind;
    int k;
    bit held;
    bit drained;
    held    = 1'b0;
    drained = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operator and paren, operands a, z, A, 0 and 9, empty result,
    // unmatched ')', '(' with nothing below it, zero and all-ones characters.
    send_text("(A-b)/c^9");
    send_text("a*0+z");
    send_text("((");
    send_text("p)");
    send_text("(q");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    send_line();
    drain_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!held && items_sent >= 150) begin
        hold_requests++;
        held = 1'b1;
      end
      if (!drained && items_sent >= 300) begin
        drain_results();
        drained = 1'b1;
      end
      no_idle = (items_sent >= 380 && items_sent < 440);

      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well-formed expression with random content
        terms = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
        depth = 0;
        for (k = 0; k < terms; k++) begin
          while ($urandom_range(0, 3) == 0 && depth < 4) begin
            line_q.push_back(CH_LPAREN);
            depth++;
          end
          line_q.push_back(random_term());
          while (depth > 0 && $urandom_range(0, 2) == 0) begin
            line_q.push_back(CH_RPAREN);
            depth--;
          end
          if (k < terms - 1) line_q.push_back(random_op());
        end
        while (depth > 0) begin
          line_q.push_back(CH_RPAREN);
          depth--;
        end
      end else begin
        // broken sequences, raw noise, or lines past capacity
        len = (kind < 95) ? $urandom_range(1, 12) : $urandom_range(33, 40);
        for (k = 0; k < len; k++) begin
          if (kind >= 85 && kind < 95) begin
            line_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            case ($urandom_range(0, 3))
              0:       line_q.push_back(random_term());
              1:       line_q.push_back(random_op());
              2:       line_q.push_back(CH_LPAREN);
              default: line_q.push_back(CH_RPAREN);
            endcase
          end
        end
      end
      send_line();
    end
    no_idle = 1'b0;

    drain_results();
    repeat (300) @(posedge clk);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("infix_to_prefix_converter regression: pass");
    end else begin
      $display("infix_to_prefix_converter regression: fail");
    end
    $finish;
  end

endmodule

// ----- infix_to_prefix_converter.f -----
rtl/core/itp_pkg.sv
rtl/core/itp_stack.sv
rtl/core/infix_to_prefix_converter.sv
tb/testbench.sv
